@@ design/ast_pkg.sv @@
`timescale 1ns / 1ps
// Package for the assembler source tokenizer: byte codes, scan modes,
// result kinds, the result record type and the output clamp helper.
// No dependencies.
package ast_pkg;

	// Default width of the line and position counters.
	localparam int COUNT_BITS_DEF = 16;

	// Depth of the result queue in front of the output port.
	localparam int QUEUE_DEPTH = 4;

	// Characters with a special meaning.
	localparam logic [7:0] CH_END       = 8'h00;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_APOS      = 8'h27;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_WS_LO     = 8'h09;
	localparam logic [7:0] CH_WS_HI     = 8'h0D;

	// Scan modes.
	localparam logic [2:0] MODE_BETWEEN = 3'd0;
	localparam logic [2:0] MODE_COMMENT = 3'd1;
	localparam logic [2:0] MODE_TOKEN   = 3'd2;
	localparam logic [2:0] MODE_LIT     = 3'd3;
	localparam logic [2:0] MODE_LIT_BS  = 3'd4;
	localparam logic [2:0] MODE_ENDED   = 3'd5;
	localparam logic [2:0] MODE_STOPPED = 3'd6;

	// Result kinds.
	localparam logic [1:0] KIND_TOKEN = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// One result item as it waits in the queue.
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] start_line;
		logic [15:0] start_offset;
		logic [15:0] token_length;
		logic        char_literal;
		logic        last_of_run;
	} result_t;

	// Clamp a counter value (zero-extended to 32 bits) to the 16-bit output range.
	function automatic logic [15:0] clamp16(input logic [31:0] v);
		clamp16 = (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

@@ design/asm_source_tokenizer_top.sv @@
`timescale 1ns / 1ps
// Top level of the assembler source tokenizer: input byte register, scan
// logic, and a small result queue in front of the output stream.
// Depends on ast_pkg.

// The tokenizer takes one source byte per cycle on the slave stream while
// the result queue has room, and reports each token's start line, start
// offset and length on the master stream, followed by an end marker when
// byte 0 arrives. A byte passes an input register and is scanned from there
// once the queue has room; its results are written to the result queue and
// offered on the master stream from the queue head. The scan logic writes into a
// four-entry result queue and takes a byte only while at least two entries
// are free; with the output side always ready this never stalls, so the
// sustained rate is one byte per cycle. An unterminated literal gives an
// error result, after which all bytes are taken and dropped until reset, as
// are all bytes after the end marker.
module asm_source_tokenizer_top
	import ast_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [15:0] start_line, [31:16] start_offset,
	                                    // [47:32] token_length, [48] char_literal,
	                                    // [55:49] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast    // last_of_run
);

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [CNT_BITS-1:0] FILL_LIMIT = CNT_BITS'(QUEUE_DEPTH - 2);

	// Input register.
	logic             valid_s1;
	logic [7:0]       byte_s1;

	// Scan state.
	logic [2:0]            mode_q;
	logic                  apos_q;
	logic [COUNT_BITS-1:0] line_q;
	logic [COUNT_BITS-1:0] pos_q;
	logic [COUNT_BITS-1:0] tok_off_q;
	logic [COUNT_BITS-1:0] tok_line_q;

	// Result queue.
	result_t               queue_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;

	// Next-state and result signals.
	logic                  advance;
	logic                  pop;
	logic [2:0]            mode_d;
	logic                  apos_d;
	logic [COUNT_BITS-1:0] line_d;
	logic [COUNT_BITS-1:0] tok_off_d;
	logic [COUNT_BITS-1:0] tok_line_d;
	logic [1:0]            n_res;
	result_t               res0;
	result_t               res1;

	// The scan step runs when the queue has room for two results.
	assign advance       = valid_s1 && (count_q <= FILL_LIMIT);
	assign s_axis_tready = !valid_s1 || advance;
	assign pop           = m_axis_tvalid && m_axis_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Scan logic for the byte in the input register.
	always_comb begin
		logic                  is_ws;
		logic                  is_quote;
		logic [7:0]            quote_ch;
		logic                  lit_scan;
		logic [COUNT_BITS-1:0] line_inc;
		logic [COUNT_BITS-1:0] tok_len;
		result_t               tok_res;
		result_t               end_res;
		result_t               err_res;

		is_ws    = (byte_s1 == CH_SPACE) || (byte_s1 >= CH_WS_LO && byte_s1 <= CH_WS_HI);
		is_quote = (byte_s1 == CH_DQUOTE) || (byte_s1 == CH_APOS);
		quote_ch = apos_q ? CH_APOS : CH_DQUOTE;
		line_inc = (line_q == COUNT_MAX) ? line_q : line_q + 1'b1;
		tok_len  = pos_q - tok_off_q;

		tok_res.kind         = KIND_TOKEN;
		tok_res.start_line   = clamp16(32'(tok_line_q));
		tok_res.start_offset = clamp16(32'(tok_off_q));
		tok_res.token_length = clamp16(32'(tok_len));
		tok_res.char_literal = 1'b0;
		tok_res.last_of_run  = 1'b1;

		end_res.kind         = KIND_END;
		end_res.start_line   = clamp16(32'(line_q));
		end_res.start_offset = 16'd0;
		end_res.token_length = 16'd0;
		end_res.char_literal = 1'b0;
		end_res.last_of_run  = 1'b1;

		err_res.kind         = KIND_ERROR;
		err_res.start_line   = clamp16(32'(line_q));
		err_res.start_offset = clamp16(32'(tok_off_q));
		err_res.token_length = 16'd0;
		err_res.char_literal = apos_q;
		err_res.last_of_run  = 1'b1;

		mode_d     = mode_q;
		apos_d     = apos_q;
		line_d     = line_q;
		tok_off_d  = tok_off_q;
		tok_line_d = tok_line_q;
		n_res      = 2'd0;
		res0       = end_res;
		res1       = end_res;
		lit_scan   = 1'b0;

		unique case (mode_q)
			MODE_BETWEEN: begin
				if (byte_s1 == CH_END) begin
					n_res  = 2'd1;
					mode_d = MODE_ENDED;
				end else if (byte_s1 == CH_SEMICOLON) begin
					mode_d = MODE_COMMENT;
				end else if (is_ws) begin
					if (byte_s1 == CH_NEWLINE) begin
						line_d = line_inc;
					end
				end else begin
					tok_off_d  = pos_q;
					tok_line_d = line_q;
					if (is_quote) begin
						apos_d = (byte_s1 == CH_APOS);
						mode_d = MODE_LIT;
					end else begin
						mode_d = MODE_TOKEN;
					end
				end
			end
			MODE_COMMENT: begin
				if (byte_s1 == CH_END) begin
					n_res  = 2'd1;
					mode_d = MODE_ENDED;
				end else if (byte_s1 == CH_NEWLINE) begin
					line_d = line_inc;
					mode_d = MODE_BETWEEN;
				end
			end
			MODE_TOKEN: begin
				if (byte_s1 == CH_END || byte_s1 == CH_SEMICOLON || is_ws) begin
					res0  = tok_res;
					n_res = 2'd1;
					if (byte_s1 == CH_END) begin
						res0.last_of_run = 1'b0;
						n_res  = 2'd2;
						mode_d = MODE_ENDED;
					end else if (byte_s1 == CH_SEMICOLON) begin
						mode_d = MODE_COMMENT;
					end else begin
						if (byte_s1 == CH_NEWLINE) begin
							line_d = line_inc;
						end
						mode_d = MODE_BETWEEN;
					end
				end else if (is_quote) begin
					apos_d = (byte_s1 == CH_APOS);
					mode_d = MODE_LIT;
				end
			end
			MODE_LIT: begin
				lit_scan = 1'b1;
			end
			MODE_LIT_BS: begin
				// An escaped closing quote stays inside the literal.
				mode_d   = MODE_LIT;
				lit_scan = (byte_s1 != quote_ch);
			end
			default: begin
			end
		endcase

		// Ordinary byte inside a literal.
		if (lit_scan) begin
			if (byte_s1 == CH_END) begin
				res0   = err_res;
				n_res  = 2'd1;
				mode_d = MODE_STOPPED;
			end else if (byte_s1 == quote_ch) begin
				mode_d = MODE_TOKEN;
			end else if (byte_s1 == CH_BACKSLASH) begin
				mode_d = MODE_LIT_BS;
			end else if (byte_s1 == CH_NEWLINE) begin
				line_d = line_inc;
			end
		end
	end

	// Scan state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_BETWEEN;
			apos_q     <= 1'b0;
			line_q     <= COUNT_BITS'(1);
			pos_q      <= '0;
			tok_off_q  <= '0;
			tok_line_q <= COUNT_BITS'(1);
		end else if (advance) begin
			mode_q     <= mode_d;
			apos_q     <= apos_d;
			line_q     <= line_d;
			tok_off_q  <= tok_off_d;
			tok_line_q <= tok_line_d;
			if (mode_d != MODE_ENDED && mode_d != MODE_STOPPED && pos_q != COUNT_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (advance ? CNT_BITS'(n_res) : '0) - CNT_BITS'(pop);
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (advance && n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (advance && n_res == 2'd2) begin
			queue_q[wr_ptr_q + 1'b1] <= res1;
		end
	end

	// Output stream from the head of the queue.
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tuser  = queue_q[rd_ptr_q].kind;
	assign m_axis_tlast  = queue_q[rd_ptr_q].last_of_run;
	assign m_axis_tdata  = {7'd0,
	                        queue_q[rd_ptr_q].char_literal,
	                        queue_q[rd_ptr_q].token_length,
	                        queue_q[rd_ptr_q].start_offset,
	                        queue_q[rd_ptr_q].start_line};

endmodule

@@ bench/tb_asm_source_tokenizer_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for asm_source_tokenizer_top: feeds source text, predicts every
// token, end marker and literal error, and checks the result stream item by item.
// Depends on ast_pkg and asm_source_tokenizer_top.
module tb_asm_source_tokenizer_top;
	import ast_pkg::*;

	// Tracks the scan state of the text fed so far and holds the results it implies.
	class token_tracker;
		logic [2:0]  scan;
		logic        in_apos;
		logic [15:0] line_no;
		logic [15:0] byte_pos;
		logic [15:0] tok_offset;
		logic [15:0] tok_line;
		result_t     awaited_results[$];
		result_t     step_results[$];
		int          errors;

		function new();
			scan       = MODE_BETWEEN;
			in_apos    = 1'b0;
			line_no    = 16'd1;
			byte_pos   = 16'd0;
			tok_offset = 16'd0;
			tok_line   = 16'd1;
			errors     = 0;
		endfunction

		// Counters stop at their maximum.
		static function logic [15:0] bump(logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		static function bit is_blank(logic [7:0] c);
			return (c == CH_SPACE) || (c >= CH_WS_LO && c <= CH_WS_HI);
		endfunction

		function logic [7:0] closing_quote();
			return in_apos ? CH_APOS : CH_DQUOTE;
		endfunction

		function void emit(logic [1:0] kind, logic [15:0] line, logic [15:0] offset,
				logic [15:0] length, logic chr);
			result_t r;
			r.kind         = kind;
			r.start_line   = line;
			r.start_offset = offset;
			r.token_length = length;
			r.char_literal = chr;
			r.last_of_run  = 1'b0;
			step_results.push_back(r);
		endfunction

		// A byte inside an open literal.
		function void literal_char(logic [7:0] c);
			if (c == CH_END) begin
				emit(KIND_ERROR, line_no, tok_offset, 16'd0, in_apos);
				scan = MODE_STOPPED;
			end else if (c == closing_quote()) begin
				scan = MODE_TOKEN;
			end else if (c == CH_BACKSLASH) begin
				scan = MODE_LIT_BS;
			end else if (c == CH_NEWLINE) begin
				line_no = bump(line_no);
			end
		endfunction

		// Advances the scan by one accepted byte and queues what it produces.
		function void take_byte(logic [7:0] c);
			step_results.delete();
			case (scan)
				MODE_BETWEEN: begin
					if (c == CH_END) begin
						emit(KIND_END, line_no, 16'd0, 16'd0, 1'b0);
						scan = MODE_ENDED;
					end else if (c == CH_SEMICOLON) begin
						scan = MODE_COMMENT;
					end else if (is_blank(c)) begin
						if (c == CH_NEWLINE)
							line_no = bump(line_no);
					end else begin
						tok_offset = byte_pos;
						tok_line   = line_no;
						if (c == CH_DQUOTE || c == CH_APOS) begin
							in_apos = (c == CH_APOS);
							scan    = MODE_LIT;
						end else begin
							scan = MODE_TOKEN;
						end
					end
				end
				MODE_COMMENT: begin
					if (c == CH_END) begin
						emit(KIND_END, line_no, 16'd0, 16'd0, 1'b0);
						scan = MODE_ENDED;
					end else if (c == CH_NEWLINE) begin
						line_no = bump(line_no);
						scan    = MODE_BETWEEN;
					end
				end
				MODE_TOKEN: begin
					if (c == CH_END || c == CH_SEMICOLON || is_blank(c)) begin
						emit(KIND_TOKEN, tok_line, tok_offset, byte_pos - tok_offset, 1'b0);
						if (c == CH_END) begin
							emit(KIND_END, line_no, 16'd0, 16'd0, 1'b0);
							scan = MODE_ENDED;
						end else if (c == CH_SEMICOLON) begin
							scan = MODE_COMMENT;
						end else begin
							if (c == CH_NEWLINE)
								line_no = bump(line_no);
							scan = MODE_BETWEEN;
						end
					end else if (c == CH_DQUOTE || c == CH_APOS) begin
						in_apos = (c == CH_APOS);
						scan    = MODE_LIT;
					end
				end
				MODE_LIT: begin
					literal_char(c);
				end
				MODE_LIT_BS: begin
					// An escaped quote stays inside the literal.
					scan = MODE_LIT;
					if (c != closing_quote())
						literal_char(c);
				end
				default: begin
					// Ended or stopped: the byte is dropped.
				end
			endcase
			if (scan != MODE_ENDED && scan != MODE_STOPPED)
				byte_pos = bump(byte_pos);
			if (step_results.size() > 0)
				step_results[step_results.size() - 1].last_of_run = 1'b1;
			foreach (step_results[i])
				awaited_results.push_back(step_results[i]);
		endfunction

		task flag_mismatch(string msg);
			errors++;
			if (errors <= 30)
				$display("mismatch: %s", msg);
		endtask

		// Compares one result item against the oldest awaited one.
		task check_result(result_t got);
			result_t want;
			if (awaited_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result kind %0d line %0d offset %0d",
					got.kind, got.start_line, got.start_offset));
				return;
			end
			want = awaited_results.pop_front();
			if (got.kind !== want.kind)
				flag_mismatch($sformatf("kind %0d, want %0d (offset %0d)",
					got.kind, want.kind, want.start_offset));
			if (got.start_line !== want.start_line)
				flag_mismatch($sformatf("start_line %0d, want %0d (offset %0d)",
					got.start_line, want.start_line, want.start_offset));
			if (got.start_offset !== want.start_offset)
				flag_mismatch($sformatf("start_offset %0d, want %0d",
					got.start_offset, want.start_offset));
			if (got.token_length !== want.token_length)
				flag_mismatch($sformatf("token_length %0d, want %0d (offset %0d)",
					got.token_length, want.token_length, want.start_offset));
			if (got.char_literal !== want.char_literal)
				flag_mismatch($sformatf("char_literal %0d, want %0d (offset %0d)",
					got.char_literal, want.char_literal, want.start_offset));
			if (got.last_of_run !== want.last_of_run)
				flag_mismatch($sformatf("last_of_run %0d, want %0d (offset %0d)",
					got.last_of_run, want.last_of_run, want.start_offset));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	token_tracker tracker;
	int           bytes_fed;
	bit           idle_on;
	int           rx_hold_req;

	asm_source_tokenizer_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#4ms;
		$display("simulation failed");
		$finish;
	end

	// Offers one text byte, with an occasional idle burst first, and waits for it to be taken.
	task push_byte(logic [7:0] c);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_byte(c);
		bytes_fed++;
		// Once in the run the receiver holds off long enough to back up the input.
		if (bytes_fed == 200)
			rx_hold_req = 400;
	endtask

	// A byte that may stand inside a token without ending it or opening a literal.
	function logic [7:0] plain_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255));
		while (token_tracker::is_blank(c) || c == CH_SEMICOLON || c == CH_DQUOTE ||
			c == CH_APOS);
		return c;
	endfunction

	function logic [7:0] blank_byte();
		int k;
		k = $urandom_range(0, 5);
		return (k == 0) ? CH_SPACE : CH_WS_LO + 8'(k - 1);
	endfunction

	// A closed literal with random content, escaped quotes and newlines.
	task send_literal(logic [7:0] q);
		logic [7:0] c;
		logic [7:0] prev;
		push_byte(q);
		prev = q;
		repeat ($urandom_range(0, 10)) begin
			c = ($urandom_range(0, 7) == 0) ? CH_NEWLINE : 8'($urandom_range(1, 255));
			if (c == q)
				push_byte(CH_BACKSLASH);
			push_byte(c);
			prev = c;
		end
		// A trailing backslash would swallow the closing quote.
		if (prev == CH_BACKSLASH)
			push_byte("x");
		push_byte(q);
	endtask

	task send_token();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 6);
		if ($urandom_range(0, 5) == 0)
			send_literal($urandom_range(0, 1) ? CH_APOS : CH_DQUOTE);
		repeat (n) push_byte(plain_byte());
		if ($urandom_range(0, 3) == 0) begin
			send_literal($urandom_range(0, 1) ? CH_APOS : CH_DQUOTE);
			if ($urandom_range(0, 1))
				push_byte(plain_byte());
		end
	endtask

	task send_comment();
		logic [7:0] c;
		push_byte(CH_SEMICOLON);
		repeat ($urandom_range(0, 8)) begin
			do c = 8'($urandom_range(1, 255)); while (c == CH_NEWLINE);
			push_byte(c);
		end
		push_byte(CH_NEWLINE);
	endtask

	// Result side: checks accepted items and stalls at random or on request.
	initial begin
		int      stall_left;
		int      hold_left;
		result_t got;
		stall_left = 0;
		hold_left  = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.kind         = m_axis_tuser;
				got.start_line   = m_axis_tdata[15:0];
				got.start_offset = m_axis_tdata[31:16];
				got.token_length = m_axis_tdata[47:32];
				got.char_literal = m_axis_tdata[48];
				got.last_of_run  = m_axis_tlast;
				tracker.check_result(got);
			end
			if (rx_hold_req > 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [7:0] opening [26] = '{
			CH_SPACE, CH_WS_LO, CH_NEWLINE, 8'h0B, 8'h0C, CH_WS_HI,
			8'hFF, 8'h80, 8'h01, CH_SEMICOLON, "x", CH_NEWLINE,
			CH_DQUOTE, "a", CH_BACKSLASH, CH_DQUOTE, CH_BACKSLASH, "b", CH_DQUOTE,
			CH_APOS, CH_DQUOTE, CH_NEWLINE, CH_APOS, CH_SPACE, "q", CH_NEWLINE
		};
		int pick;
		tracker     = new();
		bytes_fed   = 0;
		idle_on     = 1'b1;
		rx_hold_req = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Whitespace kinds, high bytes, comments, escapes and both quote kinds.
		foreach (opening[i])
			push_byte(opening[i]);

		// Mostly well-formed lines with random content, some raw noise.
		while (bytes_fed < 480) begin
			if ($urandom_range(0, 11) == 0)
				idle_on = !idle_on;
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				send_token();
				case ($urandom_range(0, 3))
					0, 1: repeat ($urandom_range(1, 3)) push_byte(blank_byte());
					2: send_comment();
					default: push_byte(CH_NEWLINE);
				endcase
			end else if (pick <= 7) begin
				send_comment();
			end else if (pick == 8) begin
				repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(1, 255)));
			end else begin
				repeat ($urandom_range(4, 12)) push_byte(blank_byte());
			end
		end

		// Last part at full rate: close any open literal, then a few plain tokens.
		idle_on = 1'b0;
		if (tracker.scan == MODE_LIT_BS)
			push_byte("x");
		if (tracker.scan == MODE_LIT)
			push_byte(tracker.closing_quote());
		push_byte(CH_NEWLINE);
		push_byte("a");
		push_byte("b");
		push_byte(CH_SPACE);
		push_byte("c");

		// One way of ending the text; the block takes and drops every byte after it.
		case ($urandom_range(0, 4))
			0: push_byte(CH_END);
			1: begin
				push_byte(CH_SPACE);
				push_byte(CH_END);
			end
			2: begin
				push_byte(CH_SEMICOLON);
				push_byte("k");
				push_byte(CH_END);
			end
			3: begin
				push_byte(CH_SPACE);
				push_byte(CH_APOS);
				push_byte("y");
				push_byte(CH_END);
			end
			default: begin
				push_byte(CH_SPACE);
				push_byte(CH_DQUOTE);
				push_byte(CH_BACKSLASH);
				push_byte(CH_END);
			end
		endcase
		repeat (4) push_byte(8'($urandom_range(0, 255)));
		s_axis_tvalid <= 1'b0;

		while (tracker.awaited_results.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
